@@ sv/rcm_pkg.sv @@
// ----------------------------------------------------------------------------
// rcm_pkg: shared types and constants of the RCM ordering core
// Widths, opcodes and status codes.
// ----------------------------------------------------------------------------
package rcm_pkg;

	localparam int unsigned MaxVertices = 1024;
	localparam int unsigned MaxEdges    = 8192;
	localparam int unsigned VW = $clog2(MaxVertices);
	localparam int unsigned EW = $clog2(MaxEdges);
	localparam int unsigned CW = VW + 1;
	localparam int unsigned KW = EW + 1;
	localparam int unsigned DW = EW + 2;

	typedef logic [1:0] opcode_t;
	localparam opcode_t OpLoad  = 2'd0;
	localparam opcode_t OpOrder = 2'd1;
	localparam opcode_t OpRead  = 2'd2;
	localparam opcode_t OpClear = 2'd3;

	typedef logic [1:0] status_t;
	localparam status_t StOk      = 2'd0;
	localparam status_t StFull    = 2'd1;
	localparam status_t StRange   = 2'd2;
	localparam status_t StNoOrder = 2'd3;

endpackage

@@ sv/reverse_cuthill_mckee_order_core.sv @@
// ----------------------------------------------------------------------------
// reverse_cuthill_mckee_order_core: RCM vertex ordering engine
// Loads directed edges, computes a reverse Cuthill-McKee labelling, reads labels.
// ----------------------------------------------------------------------------
// A clear word runs a degree clearing pass over all 1024 entries. An order word first
// clears the visited flags of the known vertices, then runs one vertex scan per root
// and one edge scan per dequeued vertex plus one per enqueued neighbour.
// busy stays high from acceptance until the result strobe; one word at a time.
// arst_n clears counts and the ordering flag, then clears every degree entry.
module reverse_cuthill_mckee_order_core (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic [1:0]                opcode,
	input  logic [rcm_pkg::VW-1:0]    from_vertex,
	input  logic [rcm_pkg::VW-1:0]    to_vertex,
	output logic                      done,
	output logic [1:0]                status,
	output logic [rcm_pkg::VW-1:0]    label,
	output logic [rcm_pkg::CW-1:0]    vertex_count,
	output logic [rcm_pkg::KW-1:0]    edge_count
);
	import rcm_pkg::*;

	typedef enum logic [5:0] {
		C_IDLE = 6'b000001,
		C_RMW  = 6'b000010,
		C_RD   = 6'b000100,
		C_ORD  = 6'b001000,
		C_OUT  = 6'b010000,
		C_CLR  = 6'b100000
	} ctl_t;

	ctl_t ctl_q;
	logic [CW-1:0] n_q;
	logic [KW-1:0] m_q;
	logic          valid_q;
	logic [VW-1:0] clr_q;     // degree clearing address
	opcode_t       op_q;
	logic [VW-1:0] a_q, b_q;
	logic [1:0]    phase_q;
	status_t       st_q;
	logic [VW-1:0] lab_q;

	// Degree RAM (total degree), edge RAMs and label RAM.
	logic          deg_we;
	logic [VW-1:0] deg_addr, eng_deg_addr;
	logic [DW-1:0] deg_wdata, deg_rdata;
	logic          edg_we;
	logic [EW-1:0] edg_addr, eng_edg_addr;
	logic [VW-1:0] src_rdata, dst_rdata;
	logic          lbl_we;
	logic [VW-1:0] lbl_addr, eng_lbl_addr, lbl_wdata, lbl_rdata;
	logic          eng_go, eng_done;

	rcm_ram #(.Width(DW), .Depth(MaxVertices)) u_deg (
		.clk, .we(deg_we), .addr(deg_addr), .wdata(deg_wdata), .rdata(deg_rdata));
	rcm_ram #(.Width(VW), .Depth(MaxEdges)) u_src (
		.clk, .we(edg_we), .addr(edg_addr), .wdata(a_q), .rdata(src_rdata));
	rcm_ram #(.Width(VW), .Depth(MaxEdges)) u_dst (
		.clk, .we(edg_we), .addr(edg_addr), .wdata(b_q), .rdata(dst_rdata));
	rcm_ram #(.Width(VW), .Depth(MaxVertices)) u_lbl (
		.clk, .we(lbl_we), .addr(lbl_addr), .wdata(lbl_wdata), .rdata(lbl_rdata));

	rcm_engine u_eng (
		.clk, .arst_n, .go(eng_go), .n(n_q), .m(m_q), .done(eng_done),
		.lbl_we(lbl_we), .lbl_addr(eng_lbl_addr), .lbl_data(lbl_wdata),
		.deg_addr(eng_deg_addr), .deg_rdata(deg_rdata),
		.edg_addr(eng_edg_addr), .src_rdata(src_rdata), .dst_rdata(dst_rdata));

	// Port muxing: the load, clear and read sequences use the RAMs only while
	// the engine idles.
	always_comb begin
		deg_addr  = eng_deg_addr;
		edg_addr  = eng_edg_addr;
		lbl_addr  = eng_lbl_addr;
		deg_we    = 1'b0;
		edg_we    = 1'b0;
		deg_wdata = deg_rdata + 1'b1;
		if (ctl_q == C_RMW) begin
			deg_addr = phase_q[1] ? b_q : a_q;
			edg_addr = m_q[EW-1:0];
			deg_we   = phase_q[0];
			edg_we   = (phase_q == 2'd3);
		end else if (ctl_q == C_CLR) begin
			deg_addr  = clr_q;
			deg_we    = 1'b1;
			deg_wdata = '0;
		end else if (ctl_q == C_RD) begin
			lbl_addr = a_q;
		end
	end

	assign eng_go = (ctl_q == C_ORD) && (phase_q == 2'd0);
	assign busy   = (ctl_q != C_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q    <= C_CLR;
			n_q      <= '0;
			m_q      <= '0;
			valid_q  <= 1'b0;
			clr_q    <= '0;
			op_q     <= OpLoad;
			phase_q  <= '0;
			done     <= 1'b0;
		end else begin
			done <= 1'b0;
			unique case (ctl_q)
				C_IDLE: begin
					if (start) begin
						op_q    <= opcode;
						a_q     <= from_vertex;
						b_q     <= to_vertex;
						phase_q <= '0;
						lab_q   <= '0;
						st_q    <= StOk;
						unique case (opcode)
							OpLoad: begin
								if (from_vertex == to_vertex) begin
									ctl_q <= C_OUT;
								end else if (m_q == KW'(MaxEdges)) begin
									st_q  <= StFull;
									ctl_q <= C_OUT;
								end else begin
									ctl_q <= C_RMW;
								end
							end
							OpOrder: ctl_q <= C_ORD;
							OpRead: begin
								if (CW'(from_vertex) >= n_q) begin
									st_q  <= StRange;
									ctl_q <= C_OUT;
								end else if (!valid_q) begin
									st_q  <= StNoOrder;
									ctl_q <= C_OUT;
								end else begin
									ctl_q <= C_RD;
								end
							end
							OpClear: begin
								n_q     <= '0;
								m_q     <= '0;
								valid_q <= 1'b0;
								clr_q   <= '0;
								ctl_q   <= C_CLR;
							end
							default: ctl_q <= C_OUT;
						endcase
					end
				end
				// Phases: read a, write a+1, read b, write b+1 and store edge.
				C_RMW: begin
					phase_q <= phase_q + 1'b1;
					if (phase_q == 2'd3) begin
						m_q     <= m_q + 1'b1;
						valid_q <= 1'b0;
						if (CW'(a_q) >= n_q && a_q >= b_q) n_q <= CW'(a_q) + 1'b1;
						else if (CW'(b_q) >= n_q) n_q <= CW'(b_q) + 1'b1;
						ctl_q <= C_OUT;
					end
				end
				// Every degree entry is zeroed; after reset no result follows.
				C_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == VW'(MaxVertices - 1)) begin
						ctl_q <= (op_q == OpClear) ? C_OUT : C_IDLE;
					end
				end
				C_RD: begin
					phase_q <= phase_q + 1'b1;
					if (phase_q == 2'd1) begin
						lab_q <= lbl_rdata;
						ctl_q <= C_OUT;
					end
				end
				C_ORD: begin
					phase_q <= 2'd1;
					if (eng_done) begin
						valid_q <= 1'b1;
						ctl_q   <= C_OUT;
					end
				end
				C_OUT: begin
					done  <= 1'b1;
					ctl_q <= C_IDLE;
				end
				default: ctl_q <= C_IDLE;
			endcase
		end
	end

	assign status       = done ? st_q : StOk;
	assign label        = done ? lab_q : '0;
	assign vertex_count = n_q;
	assign edge_count   = m_q;

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("result strobe longer than one cycle");
	a_edges_cap: assert property (@(posedge clk) disable iff (!arst_n)
		m_q <= KW'(MaxEdges)) else $error("edge count overflow");
	a_valid_nonload: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(valid_q) |-> $past(ctl_q) == C_ORD) else $error("ordering flag set");
endmodule

@@ sv/rcm_ram.sv @@
// ----------------------------------------------------------------------------
// rcm_ram: generic single-port RAM
// One address per cycle, read and optionally written; the read data is registered.
// ----------------------------------------------------------------------------
module rcm_ram #(
	parameter int unsigned Width = 8,
	parameter int unsigned Depth = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] addr,
	input  logic [Width-1:0]         wdata,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule

@@ sv/rcm_engine.sv @@
// ----------------------------------------------------------------------------
// rcm_engine: ordering sequencer
// Walks the graph with one shared compare unit: scans the vertices for the
// unvisited root of least (total degree, index) and scans the edge store for
// the least unvisited out-neighbour of the head vertex, labelling each pick.
// ----------------------------------------------------------------------------
module rcm_engine (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 go,
	input  logic [rcm_pkg::CW-1:0] n,
	input  logic [rcm_pkg::KW-1:0] m,
	output logic                 done,
	// label write port
	output logic                 lbl_we,
	output logic [rcm_pkg::VW-1:0] lbl_addr,
	output logic [rcm_pkg::VW-1:0] lbl_data,
	// degree and edge memories
	output logic [rcm_pkg::VW-1:0] deg_addr,
	input  logic [rcm_pkg::DW-1:0] deg_rdata,
	output logic [rcm_pkg::EW-1:0] edg_addr,
	input  logic [rcm_pkg::VW-1:0] src_rdata,
	input  logic [rcm_pkg::VW-1:0] dst_rdata
);
	import rcm_pkg::*;

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_VCLR  = 7'b0000010,
		S_DEQ   = 7'b0000100,
		S_DWAIT = 7'b0001000,
		S_SCAN  = 7'b0010000,
		S_PICK  = 7'b0100000,
		S_FIN   = 7'b1000000
	} state_t;

	state_t        state_q;
	logic          nb_q;       // scanning edges of now_q rather than vertices
	logic [KW-1:0] scan_q;
	logic [CW-1:0] head_q, tail_q;
	logic [VW-1:0] now_q;
	logic          ok_s1, ok_s2;
	logic [VW-1:0] idx_s1, idx_s2;
	logic          best_ok_q;
	logic [VW-1:0] best_q;
	logic [DW-1:0] best_deg_q;
	logic [KW-1:0] lim;
	logic          issue, hit, better, pick;
	logic [VW-1:0] cand_idx;
	logic          vis_we, vis_wdata, vis_rdata;
	logic [VW-1:0] vis_addr;
	logic          q_we;
	logic [VW-1:0] q_addr, q_rdata;

	// Visited flags and the visit sequence, which doubles as the BFS queue.
	rcm_ram #(.Width(1), .Depth(MaxVertices)) u_vis (
		.clk, .we(vis_we), .addr(vis_addr), .wdata(vis_wdata), .rdata(vis_rdata));
	rcm_ram #(.Width(VW), .Depth(MaxVertices)) u_queue (
		.clk, .we(q_we), .addr(q_addr), .wdata(best_q), .rdata(q_rdata));

	// A scan issues one address per cycle; the candidate vertex is known in the next
	// cycle and its degree and visited flag in the cycle after that.
	assign lim      = nb_q ? m : KW'(n);
	assign issue    = (scan_q != lim);
	assign hit      = ok_s1 && (!nb_q || (src_rdata == now_q));
	assign cand_idx = nb_q ? dst_rdata : idx_s1;

	// Shared compare unit: is the candidate less than the current best?
	assign better = !best_ok_q || (deg_rdata < best_deg_q) ||
		((deg_rdata == best_deg_q) && (idx_s2 < best_q));
	assign pick   = (state_q == S_PICK) && best_ok_q;

	assign deg_addr = cand_idx;
	assign edg_addr = scan_q[EW-1:0];
	assign done     = (state_q == S_FIN);
	assign lbl_we   = pick;
	assign lbl_addr = best_q;
	assign lbl_data = VW'(n - 1'b1 - tail_q);
	assign q_we     = pick;
	assign q_addr   = pick ? tail_q[VW-1:0] : head_q[VW-1:0];

	always_comb begin
		vis_addr  = cand_idx;
		vis_we    = 1'b0;
		vis_wdata = 1'b0;
		if (state_q == S_VCLR) begin
			vis_addr = scan_q[VW-1:0];
			vis_we   = 1'b1;
		end else if (pick) begin
			vis_addr  = best_q;
			vis_we    = 1'b1;
			vis_wdata = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			nb_q       <= 1'b0;
			scan_q     <= '0;
			head_q     <= '0;
			tail_q     <= '0;
			now_q      <= '0;
			ok_s1      <= 1'b0;
			ok_s2      <= 1'b0;
			idx_s1     <= '0;
			idx_s2     <= '0;
			best_ok_q  <= 1'b0;
			best_q     <= '0;
			best_deg_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (go) begin
						scan_q    <= '0;
						head_q    <= '0;
						tail_q    <= '0;
						nb_q      <= 1'b0;
						best_ok_q <= 1'b0;
						state_q   <= (n == '0) ? S_FIN : S_VCLR;
					end
				end
				// Clear the visited flags of all known vertices.
				S_VCLR: begin
					scan_q <= scan_q + 1'b1;
					if (scan_q + 1'b1 == KW'(n)) begin
						state_q <= S_DEQ;
					end
				end
				// An empty queue starts a new root search unless all are labelled.
				S_DEQ: begin
					if (head_q == tail_q) begin
						if (tail_q == n) begin
							state_q <= S_FIN;
						end else begin
							nb_q      <= 1'b0;
							scan_q    <= '0;
							best_ok_q <= 1'b0;
							state_q   <= S_SCAN;
						end
					end else begin
						head_q  <= head_q + 1'b1;
						state_q <= S_DWAIT;
					end
				end
				S_DWAIT: begin
					now_q     <= q_rdata;
					nb_q      <= 1'b1;
					scan_q    <= '0;
					best_ok_q <= 1'b0;
					state_q   <= S_SCAN;
				end
				S_SCAN: begin
					ok_s1  <= issue;
					idx_s1 <= scan_q[VW-1:0];
					if (issue) begin
						scan_q <= scan_q + 1'b1;
					end
					ok_s2  <= hit;
					idx_s2 <= cand_idx;
					if (ok_s2 && !vis_rdata && better) begin
						best_ok_q  <= 1'b1;
						best_q     <= idx_s2;
						best_deg_q <= deg_rdata;
					end
					if (!issue && !ok_s1 && !ok_s2) begin
						state_q <= S_PICK;
					end
				end
				// Mark, enqueue and label the pick; a neighbour pick rescans the edges.
				S_PICK: begin
					if (best_ok_q) begin
						tail_q    <= tail_q + 1'b1;
						best_ok_q <= 1'b0;
						scan_q    <= '0;
						state_q   <= nb_q ? S_SCAN : S_DEQ;
					end else begin
						state_q <= nb_q ? S_DEQ : S_FIN;
					end
				end
				S_FIN: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_head_le_tail: assert property (@(posedge clk) disable iff (!arst_n)
		head_q <= tail_q) else $error("queue head passed tail");
	a_tail_le_n: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> (tail_q <= n)) else $error("too many visits");
	a_root_found: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PICK && !nb_q) |-> best_ok_q) else $error("no root found");
endmodule

@@ dv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench: self-checking bench for reverse_cuthill_mckee_order_core
// Drives load, order, read and clear words and predicts every result word
// from an internal copy of the graph and the RCM labelling it implies.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import rcm_pkg::*;

	// Idle cycles without an accepted word or a result before giving up.
	// The slowest order word on the small graphs used here stays far below it.
	localparam int StallLimit = 400000;

	typedef struct {
		opcode_t       op;
		logic [VW-1:0] a;
		logic [VW-1:0] b;
	} word_t;

	typedef struct {
		status_t       st;
		logic [VW-1:0] lbl;
		logic [CW-1:0] vcnt;
		logic [KW-1:0] ecnt;
	} result_t;

	logic          clk;
	logic          arst_n;
	logic          start;
	logic          busy;
	opcode_t       opcode;
	logic [VW-1:0] from_vertex;
	logic [VW-1:0] to_vertex;
	logic          done;
	logic [1:0]    status;
	logic [VW-1:0] label;
	logic [CW-1:0] vertex_count;
	logic [KW-1:0] edge_count;

	reverse_cuthill_mckee_order_core dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.opcode(opcode), .from_vertex(from_vertex), .to_vertex(to_vertex),
		.done(done), .status(status), .label(label),
		.vertex_count(vertex_count), .edge_count(edge_count)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Shadow copy of the graph held by the core.
	int      edge_src [MaxEdges];
	int      edge_dst [MaxEdges];
	int      deg_total [MaxVertices];
	int      new_pos [MaxVertices];
	int      vtx_known;
	int      edges_stored;
	bit      labels_valid;

	word_t   word_q[$];
	result_t result_q[$];
	int      errors;

	// Degree-then-index ordering used for both root choice and neighbour order.
	function automatic bit deg_before(int x, int y);
		if (deg_total[x] != deg_total[y])
			return deg_total[x] < deg_total[y];
		return x < y;
	endfunction

	// Reverse Cuthill-McKee labelling of the shadow graph.
	task automatic relabel_graph();
		int roots [MaxVertices];
		int seq [MaxVertices];
		bit seen [MaxVertices];
		bit nbr [MaxVertices];
		int n, head, tail, tmp, now, j;
		n = vtx_known;
		for (int v = 0; v < n; v++) begin
			roots[v] = v;
			seen[v] = 1'b0;
		end
		for (int i = 1; i < n; i++) begin
			tmp = roots[i];
			j = i - 1;
			while (j >= 0 && deg_before(tmp, roots[j])) begin
				roots[j + 1] = roots[j];
				j--;
			end
			roots[j + 1] = tmp;
		end
		head = 0;
		tail = 0;
		for (int k = 0; k < n; k++) begin
			if (!seen[roots[k]]) begin
				seen[roots[k]] = 1'b1;
				seq[tail++] = roots[k];
				while (head < tail) begin
					now = seq[head++];
					for (int v = 0; v < n; v++)
						nbr[v] = 1'b0;
					for (int e = 0; e < edges_stored; e++)
						if (edge_src[e] == now)
							nbr[edge_dst[e]] = 1'b1;
					// Out-neighbours are enqueued in the order of the root ranking.
					for (int r = 0; r < n; r++) begin
						if (nbr[roots[r]] && !seen[roots[r]]) begin
							seen[roots[r]] = 1'b1;
							seq[tail++] = roots[r];
						end
					end
				end
			end
		end
		for (int k = 0; k < tail; k++)
			new_pos[seq[k]] = n - 1 - k;
		labels_valid = 1'b1;
	endtask

	task automatic clear_graph();
		for (int v = 0; v < MaxVertices; v++) begin
			deg_total[v] = 0;
		end
		vtx_known = 0;
		edges_stored = 0;
		labels_valid = 1'b0;
	endtask

	// Applies one accepted word to the shadow graph and returns its result.
	task automatic apply_word(input word_t w, output result_t r);
		r.st = StOk;
		r.lbl = '0;
		case (w.op)
			OpLoad: begin
				// Self-loops are dropped silently; ids always fit in ten bits.
				if (w.a != w.b) begin
					if (edges_stored >= MaxEdges) begin
						r.st = StFull;
					end else begin
						edge_src[edges_stored] = w.a;
						edge_dst[edges_stored] = w.b;
						edges_stored++;
						deg_total[w.a]++;
						deg_total[w.b]++;
						if (w.a + 1 > vtx_known) vtx_known = w.a + 1;
						if (w.b + 1 > vtx_known) vtx_known = w.b + 1;
						labels_valid = 1'b0;
					end
				end
			end
			OpOrder: begin
				relabel_graph();
			end
			OpRead: begin
				if (w.a >= vtx_known)
					r.st = StRange;
				else if (!labels_valid)
					r.st = StNoOrder;
				else
					r.lbl = VW'(new_pos[w.a]);
			end
			default: begin
				clear_graph();
			end
		endcase
		r.vcnt = CW'(vtx_known);
		r.ecnt = KW'(edges_stored);
	endtask

	function automatic word_t mk(opcode_t op, int a, int b);
		word_t w;
		w.op = op;
		w.a = VW'(a);
		w.b = VW'(b);
		return w;
	endfunction

	function automatic void add_word(word_t w);
		word_q.insert(word_q.size(), w);
	endfunction

	// Driver: words change at the falling edge, with an idle gap drawn at random
	// per word. A word that follows back to back keeps start high.
	int  gap;
	bit  took;

	always @(negedge clk) begin
		if (arst_n) begin
			if (start && took) begin
				gap = $urandom_range(0, 4);
				if ($urandom_range(0, 7) == 0)
					gap = 0;
				if (gap == 0 && word_q.size() > 0) begin
					word_t w;
					w = word_q.pop_front();
					opcode <= w.op;
					from_vertex <= w.a;
					to_vertex <= w.b;
				end else begin
					start <= 1'b0;
					if (gap > 0)
						gap--;
				end
			end else if (!start) begin
				if (gap > 0) begin
					gap--;
				end else if (word_q.size() > 0) begin
					word_t w;
					w = word_q.pop_front();
					opcode <= w.op;
					from_vertex <= w.a;
					to_vertex <= w.b;
					start <= 1'b1;
				end
			end
		end
	end

	// Monitor: acceptance and results are both sampled at the rising edge.
	int quiet;

	always @(posedge clk) begin
		result_t exp_r;
		word_t   w;
		took <= start && !busy;
		quiet++;
		if (arst_n && start && !busy) begin
			w.op = opcode;
			w.a = from_vertex;
			w.b = to_vertex;
			apply_word(w, exp_r);
			result_q.insert(result_q.size(), exp_r);
			quiet = 0;
		end
		if (arst_n && done) begin
			quiet = 0;
			if (result_q.size() == 0) begin
				$display("%0t: result word with none expected: status %0d label %0d",
					$realtime, status, label);
				errors++;
			end else begin
				exp_r = result_q.pop_front();
				if (status !== exp_r.st) begin
					$display("%0t: status expected %0d actual %0d", $realtime, exp_r.st, status);
					errors++;
				end
				if (label !== exp_r.lbl) begin
					$display("%0t: label expected %0d actual %0d", $realtime, exp_r.lbl, label);
					errors++;
				end
				if (vertex_count !== exp_r.vcnt) begin
					$display("%0t: vertex_count expected %0d actual %0d", $realtime,
						exp_r.vcnt, vertex_count);
					errors++;
				end
				if (edge_count !== exp_r.ecnt) begin
					$display("%0t: edge_count expected %0d actual %0d", $realtime,
						exp_r.ecnt, edge_count);
					errors++;
				end
			end
		end
		if (quiet >= StallLimit) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// Random graph on ids below nv, then order it and read labels back.
	task automatic queue_graph_round(int nv, int ne);
		int a, b;
		add_word(mk(OpClear, $urandom_range(0, 1023), $urandom_range(0, 1023)));
		for (int i = 0; i < ne; i++) begin
			a = $urandom_range(0, nv - 1);
			b = ($urandom_range(0, 9) == 0) ? a : $urandom_range(0, nv - 1);
			add_word(mk(OpLoad, a, b));
		end
		if ($urandom_range(0, 2) == 0)
			add_word(mk(OpRead, $urandom_range(0, nv - 1), $urandom));
		add_word(mk(OpOrder, $urandom, $urandom));
		for (int i = 0; i < nv / 2 + 4; i++) begin
			a = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, nv);
			add_word(mk(OpRead, a, $urandom));
		end
		// A late edge invalidates the labelling until the next order word.
		if ($urandom_range(0, 2) == 0) begin
			a = $urandom_range(0, nv - 1);
			b = (a + 1) % nv;
			add_word(mk(OpLoad, a, b));
			add_word(mk(OpRead, $urandom_range(0, nv - 1), $urandom));
			add_word(mk(OpOrder, 0, 0));
			for (int i = 0; i < 4; i++)
				add_word(mk(OpRead, $urandom_range(0, nv - 1), $urandom));
		end
	endtask

	initial begin
		int nv;
		arst_n = 1'b0;
		start = 1'b0;
		opcode = OpLoad;
		from_vertex = '0;
		to_vertex = '0;
		gap = 0;
		took = 1'b0;
		quiet = 0;
		errors = 0;
		clear_graph();

		// Directed part: reads on an empty core, ordering an empty graph,
		// self-loops at the id extremes and the largest ids.
		add_word(mk(OpRead, 0, 0));
		add_word(mk(OpOrder, 0, 0));
		add_word(mk(OpRead, 0, 1023));
		add_word(mk(OpLoad, 1023, 1023));
		add_word(mk(OpLoad, 0, 0));
		add_word(mk(OpLoad, 0, 1023));
		add_word(mk(OpLoad, 1023, 0));
		add_word(mk(OpRead, 1023, 0));
		add_word(mk(OpRead, 1022, 0));
		add_word(mk(OpClear, 0, 0));
		add_word(mk(OpLoad, 0, 1));
		add_word(mk(OpLoad, 1, 2));
		add_word(mk(OpLoad, 3, 1));
		add_word(mk(OpLoad, 2, 2));
		add_word(mk(OpRead, 1, 0));
		add_word(mk(OpOrder, 0, 0));
		for (int v = 0; v < 5; v++)
			add_word(mk(OpRead, v, 0));
		add_word(mk(OpLoad, 4, 0));
		add_word(mk(OpRead, 0, 0));
		add_word(mk(OpOrder, 0, 0));
		add_word(mk(OpRead, 4, 0));

		// Random part: mostly small graphs ordered and read back.
		while (word_q.size() < 1580) begin
			nv = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 48) : $urandom_range(2, 16);
			queue_graph_round(nv, $urandom_range(0, 3 * nv));
			if ($urandom_range(0, 5) == 0) begin
				// An id drawn from the full range can make the graph huge; it is cleared without ordering.
				add_word(mk(OpLoad, $urandom_range(0, 1023), $urandom_range(0, 1023)));
				add_word(mk(OpRead, $urandom_range(0, 1023), $urandom));
			end
		end
		add_word(mk(OpClear, 0, 0));

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		wait (word_q.size() == 0 && !start && result_q.size() == 0);
		repeat (20) @(posedge clk);
		if (errors == 0 && result_q.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

@@ files.f @@
sv/rcm_pkg.sv
sv/rcm_ram.sv
sv/rcm_engine.sv
sv/reverse_cuthill_mckee_order_core.sv
dv/testbench.sv
